// File: design/mtfdtc_pkg.sv
// Shared types and constants for the move-to-front decoder with trigram cost.
// Used by mtfdtc_list and mtf_decode_trigram_cost; depends on nothing else.
package mtfdtc_pkg;

    localparam int SYM_W          = 5;
    localparam int IDX_W          = 15;
    localparam int COST_W         = 32;
    localparam int TOTAL_W        = 48;
    localparam int OPC_W          = 3;

    localparam logic [SYM_W-1:0] BOS       = SYM_W'(27);
    localparam logic [SYM_W-1:0] SPACE_SYM = SYM_W'(26);
    localparam logic [SYM_W-1:0] SPACE     = SYM_W'(25);

    localparam int HIST_STRIDE    = 28;
    localparam int SYM_STRIDE     = 27;
    localparam int COST_DEPTH     = HIST_STRIDE * HIST_STRIDE * SYM_STRIDE;

    typedef enum logic [OPC_W-1:0] {
        OP_LOAD_RANK = 3'd0,
        OP_LOAD_INIT = 3'd1,
        OP_LOAD_COST = 3'd2,
        OP_TOKEN     = 3'd3,
        OP_CLEAR     = 3'd4
    } opcode_t;

    // Control from the top level to the list unit.
    typedef struct packed {
        logic                    rank_we;
        logic                    init_we;
        logic                    step;
        logic                    new_line;
        logic                    is_space;
        logic [SYM_W-1:0]        token;
        logic [IDX_W-1:0]        index;
        logic signed [COST_W-1:0] value;
    } list_ctl_t;

endpackage

// File: design/mtfdtc_list.sv
// Move-to-front list, rank table and initial order, all in registers.
// Decodes one token per step and shifts the list; depends on mtfdtc_pkg.
module mtfdtc_list #(
    parameter int LETTERS = 26,
    parameter int SOURCES = 25
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mtfdtc_pkg::list_ctl_t       ctl,
    output logic [mtfdtc_pkg::SYM_W-1:0] sym
);
    import mtfdtc_pkg::*;

    localparam int LW = $clog2(LETTERS);
    localparam int SW = $clog2(SOURCES);
    localparam logic signed [COST_W-1:0] LETTER_MAX = COST_W'(LETTERS - 1);

    logic [SYM_W-1:0] list_reg [LETTERS];
    logic [SYM_W-1:0] list_next [LETTERS];
    logic [SYM_W-1:0] init_reg [LETTERS];
    logic [SYM_W-1:0] rank_reg [SOURCES];
    logic [SYM_W-1:0] src [LETTERS];
    logic [SYM_W-1:0] letter;
    logic [SYM_W-1:0] rank;
    logic [LW-1:0]    ridx;

    // Load values are clamped into the letter range.
    always_comb
    begin
        if (ctl.value < 0)
            letter = '0;
        else if (ctl.value > LETTER_MAX)
            letter = SYM_W'(LETTERS - 1);
        else
            letter = ctl.value[SYM_W-1:0];
    end

    always_comb
    begin
        for (int j = 0; j < LETTERS; j++)
            src[j] = ctl.new_line ? init_reg[j] : list_reg[j];
        rank = rank_reg[ctl.token[SW-1:0]];
        ridx = rank[LW-1:0];
        sym  = ctl.is_space ? SPACE_SYM : src[ridx];
        list_next[0] = ctl.is_space ? src[0] : sym;
        for (int j = 1; j < LETTERS; j++)
        begin
            if (!ctl.is_space && LW'(j) <= ridx)
                list_next[j] = src[j-1];
            else
                list_next[j] = src[j];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rank_we && ctl.index < IDX_W'(SOURCES))
            rank_reg[ctl.index[SW-1:0]] <= letter;
        if (ctl.init_we && ctl.index < IDX_W'(LETTERS))
            init_reg[ctl.index[LW-1:0]] <= letter;
        if (ctl.step)
            list_reg <= list_next;
    end

    a_front_is_symbol: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.step && !ctl.is_space |=> list_reg[0] == $past(sym))
        else $error("decoded letter did not move to the front");

    a_space_keeps_list: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.step && ctl.is_space && !ctl.new_line |=> $stable(list_reg[0]))
        else $error("space changed the list");

    a_no_step_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.step && (ctl.rank_we || ctl.init_we)))
        else $error("list step and table load in the same cycle");

endmodule

// File: design/mtf_decode_trigram_cost.sv
// Top level of the move-to-front decoder with a saturating trigram cost total.
// Holds the cost RAM, history and accumulator; uses mtfdtc_list and mtfdtc_pkg.
//
// Channel  Dir  Fields (low bit first)
// s_*      in   tdata: table_index, table_value, token; tuser: opcode, new_line
// m_*      out  tdata: decoded_symbol, running_total; tuser: saturated
//
// A token's list decode and cost RAM read happen when it is accepted; the
// registered RAM data is added to the total once the output register is free.
// While a token waits for the output register, s_tready stays low.
// Reset clears control, history and the total; tables hold no reset value.
module mtf_decode_trigram_cost #(
    parameter int LETTERS = 26,
    parameter int SOURCES = 25
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // table_index[14:0], table_value[46:15], token[51:47]
    input  logic [3:0]  s_tuser,   // opcode[2:0], new_line[3]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // decoded_symbol[4:0], running_total[52:5]
    output logic [0:0]  m_tuser    // saturated[0]
);
    import mtfdtc_pkg::*;

    logic                     accept;
    opcode_t                  opcode;
    logic [IDX_W-1:0]         table_index;
    logic signed [COST_W-1:0] table_value;
    logic [SYM_W-1:0]         token;
    logic                     new_line;
    logic                     token_ok;
    logic                     token_go;
    list_ctl_t                ctl;
    logic [SYM_W-1:0]         sym;

    logic [SYM_W-1:0]         hist_a;
    logic [SYM_W-1:0]         hist_b;
    logic [IDX_W-1:0]         cost_addr;
    logic                     addr_ok;

    logic                     pend_reg;
    logic                     addr_ok_reg;
    logic [SYM_W-1:0]         sym_reg;
    logic [SYM_W-1:0]         older_reg;
    logic [SYM_W-1:0]         newer_reg;
    logic signed [TOTAL_W-1:0] total_reg;
    logic                     sat_reg;
    logic                     m_tvalid_reg;
    logic [SYM_W-1:0]         out_sym_reg;
    logic signed [TOTAL_W-1:0] out_total_reg;
    logic                     out_sat_reg;

    logic [COST_W-1:0]        cost_mem [COST_DEPTH];
    logic [COST_W-1:0]        cost_rdata_reg;

    logic                     out_free;
    logic signed [COST_W-1:0] cost;
    logic signed [TOTAL_W:0]  sum;
    logic signed [TOTAL_W-1:0] total_next;
    logic                     clip;

    assign opcode      = opcode_t'(s_tuser[2:0]);
    assign new_line    = s_tuser[3];
    assign table_index = s_tdata[14:0];
    assign table_value = s_tdata[46:15];
    assign token       = s_tdata[51:47];

    assign s_tready = !pend_reg;
    assign accept   = s_tvalid && s_tready;
    assign token_ok = (token == SPACE) || ({1'b0, token} < (SYM_W+1)'(SOURCES));
    assign token_go = accept && (opcode == OP_TOKEN) && token_ok;

    always_comb
    begin
        ctl          = '0;
        ctl.rank_we  = accept && (opcode == OP_LOAD_RANK);
        ctl.init_we  = accept && (opcode == OP_LOAD_INIT);
        ctl.step     = token_go;
        ctl.new_line = new_line;
        ctl.is_space = (token == SPACE);
        ctl.token    = token;
        ctl.index    = table_index;
        ctl.value    = table_value;
    end

    mtfdtc_list #(
        .LETTERS (LETTERS),
        .SOURCES (SOURCES)
    ) u_list (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .sym   (sym)
    );

    // Trigram address (a * 28 + b) * 27 + c; a new line starts from begin of line.
    assign hist_a    = new_line ? BOS : older_reg;
    assign hist_b    = new_line ? BOS : newer_reg;
    assign cost_addr = (IDX_W'(hist_a) * IDX_W'(HIST_STRIDE) + IDX_W'(hist_b))
                       * IDX_W'(SYM_STRIDE) + IDX_W'(sym);
    assign addr_ok   = cost_addr < IDX_W'(COST_DEPTH);

    always_ff @(posedge clk)
    begin
        if (accept && opcode == OP_LOAD_COST && table_index < IDX_W'(COST_DEPTH))
            cost_mem[table_index] <= table_value;
        if (token_go)
            cost_rdata_reg <= cost_mem[addr_ok ? cost_addr : '0];
    end

    assign out_free   = !m_tvalid_reg || m_tready;
    assign cost       = addr_ok_reg ? cost_rdata_reg : '0;
    assign sum        = (TOTAL_W+1)'(total_reg) + (TOTAL_W+1)'(cost);
    assign clip       = sum[TOTAL_W] != sum[TOTAL_W-1];
    assign total_next = !clip ? sum[TOTAL_W-1:0]
                      : sum[TOTAL_W] ? {1'b1, {(TOTAL_W-1){1'b0}}}
                      : {1'b0, {(TOTAL_W-1){1'b1}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg     <= 1'b0;
            older_reg    <= BOS;
            newer_reg    <= BOS;
            total_reg    <= '0;
            sat_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (token_go)
            begin
                pend_reg  <= 1'b1;
                older_reg <= hist_b;
                newer_reg <= sym;
            end
            if (accept && opcode == OP_CLEAR)
            begin
                total_reg <= '0;
                sat_reg   <= 1'b0;
            end
            if (pend_reg && out_free)
            begin
                pend_reg     <= 1'b0;
                total_reg    <= total_next;
                sat_reg      <= sat_reg || clip;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (token_go)
        begin
            sym_reg     <= sym;
            addr_ok_reg <= addr_ok;
        end
        if (pend_reg && out_free)
        begin
            out_sym_reg   <= sym_reg;
            out_total_reg <= total_next;
            out_sat_reg   <= sat_reg || clip;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, out_total_reg, out_sym_reg};
    assign m_tuser  = out_sat_reg;

    a_token_pends: assert property (@(posedge clk) disable iff (!rst_n)
        token_go |=> pend_reg)
        else $error("accepted token did not start a cost read");

    a_pend_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg && out_free |=> m_tvalid_reg && !pend_reg)
        else $error("pending token did not reach the output register");

    a_sat_from_clip: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(sat_reg) |-> $past(pend_reg && out_free))
        else $error("saturation flag set outside an accumulation");

    a_history_shift: assert property (@(posedge clk) disable iff (!rst_n)
        token_go |=> newer_reg == sym_reg)
        else $error("history not updated with the decoded symbol");

endmodule
